// ----- sv/npsj_pkg.sv -----
// Shared constants, types and register codes of the nine-point stencil Jacobi core.
package npsj_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int WIDTH_W        = 12;
    localparam int ROW_W          = 16;
    localparam int DATA_W         = 32;
    localparam int COEF_FRAC_BITS = 30;
    localparam int ACC_W          = 68;
    localparam int QUOT_W         = ACC_W - COEF_FRAC_BITS;
    localparam int MIN_DIM        = 3;
    localparam int CLR_W          = COL_W + 1;
    localparam int LINE_W         = 3 * DATA_W;
    localparam int OFIFO_DEPTH    = 8;
    localparam int OFIFO_AW       = $clog2(OFIFO_DEPTH);
    localparam int CFG_IDX_W      = 3;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t COEF_SIDE_X_RST = 32'sd214748365;
    localparam data_t COEF_SIDE_Y_RST = 32'sd214748365;
    localparam data_t COEF_CORNER_RST = 32'sd53687091;
    localparam data_t COEF_SOURCE_RST = 32'sd430;
    localparam logic [WIDTH_W-1:0] GRID_WIDTH_RST  = 12'd2000;
    localparam logic [ROW_W-1:0]   GRID_HEIGHT_RST = 16'd2000;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam data_t SAT_MAX = 32'sh7FFF_FFFF;
    localparam data_t SAT_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_SIDE_X = 3'd0,
        REG_COEF_SIDE_Y = 3'd1,
        REG_COEF_CORNER = 3'd2,
        REG_COEF_SOURCE = 3'd3,
        REG_GRID_WIDTH  = 3'd4,
        REG_GRID_HEIGHT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        data_t               coef_side_x;
        data_t               coef_side_y;
        data_t               coef_corner;
        data_t               coef_source;
        logic [WIDTH_W-1:0]  grid_width;
        logic [ROW_W-1:0]    grid_height;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

    typedef struct packed {
        data_t left;
        data_t right;
        data_t up;
        data_t down;
        data_t nw;
        data_t ne;
        data_t sw;
        data_t se;
        data_t src;
    } win_t;

    typedef struct packed {
        data_t new_value;
        meta_t meta;
    } res_t;

endpackage

// ----- sv/npsj_if.sv -----
// Stream channel interfaces: cell input items and update result items.
interface npsj_in_if;
    import npsj_pkg::*;

    logic  valid;
    logic  ready;
    data_t grid_value;
    data_t source_value;

    modport source (output valid, output grid_value, output source_value, input ready);
    modport sink   (input valid, input grid_value, input source_value, output ready);
endinterface

interface npsj_out_if;
    import npsj_pkg::*;

    logic             valid;
    logic             ready;
    data_t            new_value;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_grid;

    modport source (output valid, output new_value, output out_row, output out_col,
                    output last_of_grid, input ready);
    modport sink   (input valid, input new_value, input out_row, input out_col,
                    input last_of_grid, output ready);
endinterface

// ----- sv/npsj_lbuf.sv -----
// Line buffer memory, position counters and 3x3 window registers.
module npsj_lbuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  npsj_pkg::data_t grid_value,
    input  npsj_pkg::data_t source_value,
    input  npsj_pkg::cfg_t cfg,
    output logic           clearing,
    output logic           busy,
    output logic           win_valid,
    output npsj_pkg::win_t win,
    output npsj_pkg::meta_t meta
);
    import npsj_pkg::*;

    // entry = {upper row grid, middle row grid, previous row source}
    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic             v1_reg;
    logic             emit1_reg;
    logic [COL_W-1:0] addr1_reg;
    data_t            g1_reg, s1_reg;
    meta_t            meta1_reg;

    data_t t1_reg, t2_reg, m1_reg, m2_reg, b1_reg, b2_reg, sdly_reg;

    logic [WIDTH_W-1:0] w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic               row_end, last_row, emit0;
    meta_t              meta0;
    data_t              top_rd, mid_rd, src_rd;

    assign clearing = !clr_cnt_reg[CLR_W-1];
    assign busy     = v1_reg;

    always_comb
    begin
        if (cfg.grid_width < WIDTH_W'(MIN_DIM))
            w_eff = WIDTH_W'(MIN_DIM);
        else if (cfg.grid_width > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = cfg.grid_width;

        if (cfg.grid_height < ROW_W'(MIN_DIM))
            h_eff = ROW_W'(MIN_DIM);
        else
            h_eff = cfg.grid_height;

        row_end  = (WIDTH_W'(col_reg) + WIDTH_W'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + (ROW_W + 1)'(1)) >= {1'b0, h_eff};
        emit0    = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

        meta0.row  = row_reg - ROW_W'(1);
        meta0.col  = col_reg - COL_W'(1);
        meta0.last = row_end && last_row;

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end

        clr_cnt_next = clearing ? clr_cnt_reg + CLR_W'(1) : clr_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            clr_cnt_reg <= '0;
            v1_reg      <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            clr_cnt_reg <= clr_cnt_next;
            v1_reg      <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr1_reg <= col_reg;
            g1_reg    <= grid_value;
            s1_reg    <= source_value;
            emit1_reg <= emit0;
            meta1_reg <= meta0;
        end
    end

    assign top_rd = rd_reg[3*DATA_W-1:2*DATA_W];
    assign mid_rd = rd_reg[2*DATA_W-1:DATA_W];
    assign src_rd = rd_reg[DATA_W-1:0];

    // Consecutive items always use different columns, so the write-back of one
    // item never meets the read of the next at the same entry.
    always_ff @(posedge clk)
    begin
        if (clearing)
            line_mem[clr_cnt_reg[COL_W-1:0]] <= '0;
        else if (v1_reg)
            line_mem[addr1_reg] <= {mid_rd, g1_reg, s1_reg};
        if (accept)
            rd_reg <= line_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            t1_reg   <= t2_reg;
            t2_reg   <= top_rd;
            m1_reg   <= m2_reg;
            m2_reg   <= mid_rd;
            b1_reg   <= b2_reg;
            b2_reg   <= g1_reg;
            sdly_reg <= src_rd;
        end
    end

    // window after this item's shift, center column unused
    always_comb
    begin
        win.left  = m1_reg;
        win.right = mid_rd;
        win.up    = t2_reg;
        win.down  = b2_reg;
        win.nw    = t1_reg;
        win.ne    = top_rd;
        win.sw    = b1_reg;
        win.se    = g1_reg;
        win.src   = sdly_reg;
    end

    assign win_valid = v1_reg && emit1_reg;
    assign meta      = meta1_reg;

endmodule

// ----- sv/npsj_mac.sv -----
// Four-stage weighted sum with rounding and saturation.
module npsj_mac (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  npsj_pkg::win_t  win,
    input  npsj_pkg::meta_t meta,
    input  npsj_pkg::cfg_t  cfg,
    output logic            res_valid,
    output npsj_pkg::res_t  res,
    output logic [2:0]      inflight
);
    import npsj_pkg::*;

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    meta_t m2_reg, m3_reg, m4_reg, m5_reg;

    logic signed [DATA_W:0]   sx2_reg, sy2_reg;
    logic signed [DATA_W+1:0] cs2_reg;
    data_t                    src2_reg;

    logic signed [2*DATA_W:0]   px_next, py_next, px3_reg, py3_reg;
    logic signed [2*DATA_W+1:0] pc_next, pc3_reg;
    logic signed [2*DATA_W-1:0] ps_next, ps3_reg;

    logic signed [ACC_W-1:0] a4_reg, b4_reg, t5_reg;
    logic signed [QUOT_W-1:0] quot;
    logic [QUOT_W-DATA_W:0]   quot_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // pair and corner sums
    always_ff @(posedge clk)
    begin
        sx2_reg  <= (DATA_W + 1)'(win.left) + (DATA_W + 1)'(win.right);
        sy2_reg  <= (DATA_W + 1)'(win.up) + (DATA_W + 1)'(win.down);
        cs2_reg  <= (DATA_W + 2)'(win.nw) + (DATA_W + 2)'(win.ne)
                  + (DATA_W + 2)'(win.sw) + (DATA_W + 2)'(win.se);
        src2_reg <= win.src;
        m2_reg   <= meta;
    end

    assign px_next = cfg.coef_side_x * sx2_reg;
    assign py_next = cfg.coef_side_y * sy2_reg;
    assign pc_next = cfg.coef_corner * cs2_reg;
    assign ps_next = cfg.coef_source * src2_reg;

    always_ff @(posedge clk)
    begin
        px3_reg <= px_next;
        py3_reg <= py_next;
        pc3_reg <= pc_next;
        ps3_reg <= ps_next;
        m3_reg  <= m2_reg;

        a4_reg  <= ACC_W'(px3_reg) + ACC_W'(py3_reg);
        b4_reg  <= ACC_W'(pc3_reg) + ACC_W'(ps3_reg) + ROUND_HALF;
        m4_reg  <= m3_reg;

        t5_reg  <= a4_reg + b4_reg;
        m5_reg  <= m4_reg;
    end

    assign quot    = t5_reg[ACC_W-1:COEF_FRAC_BITS];
    assign quot_hi = quot[QUOT_W-1:DATA_W-1];

    always_comb
    begin
        if (quot_hi == '0 || quot_hi == '1)
            res.new_value = quot[DATA_W-1:0];
        else if (quot[QUOT_W-1])
            res.new_value = SAT_MIN;
        else
            res.new_value = SAT_MAX;
        res.meta = m5_reg;
    end

    assign res_valid = v5_reg;
    assign inflight  = 3'(v2_reg) + 3'(v3_reg) + 3'(v4_reg) + 3'(v5_reg);

endmodule

// ----- sv/npsj_ofifo.sv -----
// Result FIFO; the input side holds back items so it never overflows.
module npsj_ofifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  npsj_pkg::res_t              push_data,
    npsj_out_if.source                  result,
    output logic [npsj_pkg::OFIFO_AW:0] count
);
    import npsj_pkg::*;

    res_t                fifo_reg [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OFIFO_AW:0]   count_reg;
    logic                pop;
    res_t                head;

    assign pop   = result.valid && result.ready;
    assign count = count_reg;
    assign head  = fifo_reg[rd_ptr_reg];

    assign result.valid        = count_reg != '0;
    assign result.new_value    = head.new_value;
    assign result.out_row      = head.meta.row;
    assign result.out_col      = head.meta.col;
    assign result.last_of_grid = head.meta.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OFIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OFIFO_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (OFIFO_AW + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (OFIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/nine_point_stencil_jacobi_step_core.sv -----
// Top level of the nine-point stencil Jacobi update core.
// Cells stream in row-major order, one item per cycle while ready is high; an update
// leaves for every interior cell, delayed by one row plus one column of input and by the
// pipeline registers. The line buffer is a single memory read at one column and written
// back the next cycle, and the four multiplies sit in their own stage, so the sustained
// rate is one item per clock while results drain. Results queue in an eight-entry FIFO;
// input ready drops when the items in flight could fill it. After reset the line buffer
// is cleared, during which no item is taken (configuration writes are). Coefficients and
// grid size must be written only while the core is idle; the core does not enforce this.
module nine_point_stencil_jacobi_step_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    npsj_in_if.sink                               feed,
    npsj_out_if.source                            result,
    input  logic                                  cfg_we,
    input  logic [npsj_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [npsj_pkg::DATA_W-1:0]           cfg_data
);
    import npsj_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic              accept;
    logic              clearing;
    logic              lbuf_busy;
    logic              win_valid;
    win_t              win;
    meta_t             win_meta;
    logic              res_valid;
    res_t              res;
    logic [2:0]        inflight;
    logic [OFIFO_AW:0] fifo_count;
    logic [OFIFO_AW+1:0] occupancy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_COEF_SIDE_X: cfg_next.coef_side_x = cfg_data;
                REG_COEF_SIDE_Y: cfg_next.coef_side_y = cfg_data;
                REG_COEF_CORNER: cfg_next.coef_corner = cfg_data;
                REG_COEF_SOURCE: cfg_next.coef_source = cfg_data;
                REG_GRID_WIDTH:  cfg_next.grid_width  = cfg_data[WIDTH_W-1:0];
                REG_GRID_HEIGHT: cfg_next.grid_height = cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_side_x <= COEF_SIDE_X_RST;
            cfg_reg.coef_side_y <= COEF_SIDE_Y_RST;
            cfg_reg.coef_corner <= COEF_CORNER_RST;
            cfg_reg.coef_source <= COEF_SOURCE_RST;
            cfg_reg.grid_width  <= GRID_WIDTH_RST;
            cfg_reg.grid_height <= GRID_HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // every item in flight holds a FIFO slot in reserve
    assign occupancy  = (OFIFO_AW + 2)'(fifo_count) + (OFIFO_AW + 2)'(inflight)
                      + (OFIFO_AW + 2)'(lbuf_busy);
    assign feed.ready = !clearing && (occupancy < (OFIFO_AW + 2)'(OFIFO_DEPTH));
    assign accept     = feed.valid && feed.ready;

    npsj_lbuf u_lbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .grid_value   (feed.grid_value),
        .source_value (feed.source_value),
        .cfg          (cfg_reg),
        .clearing     (clearing),
        .busy         (lbuf_busy),
        .win_valid    (win_valid),
        .win          (win),
        .meta         (win_meta)
    );

    npsj_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .win       (win),
        .meta      (win_meta),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res),
        .inflight  (inflight)
    );

    npsj_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .result    (result),
        .count     (fifo_count)
    );

endmodule
